// File: rtl/assert_macros.svh
// Assertion macros shared by the palette matcher modules.
// Depends on signals named clock and reset in the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define NPCM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// An implication checked in the same cycle outside reset.
`define NPCM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/npcm_pkg.sv
// Package for the nearest palette color matcher: widths, palette table,
// the word type handed along the cell chain and the digit encoder.
// No dependencies.
package npcm_pkg;

   // Number of palette entries searched, from 2 up to TABLE_ENTRIES.
   localparam int PALETTE_SIZE  = 32;
   localparam int TABLE_ENTRIES = 32;

   localparam int CHAN_W = 8;
   localparam int IDX_W  = 5;
   localparam int DIST_W = 18;
   localparam int SQ_W   = 2 * CHAN_W;
   localparam int CHAR_W = 7;

   // Registers between the edge that takes a word and the edge that takes
   // its result: one per cell plus the output register.
   localparam int LATENCY = PALETTE_SIZE + 1;

   // ASCII encoding of a base-32 digit.
   localparam logic [CHAR_W-1:0] CHAR_ZERO       = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 7'd87;
   localparam logic [IDX_W-1:0]  DEC_DIGITS      = 5'd10;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   // Word handed from one cell to the next.
   typedef struct packed {
      logic              valid;
      rgb_type           pixel;
      logic              row_end;
      logic [IDX_W-1:0]  best_idx;
      logic [DIST_W-1:0] best_dist;
   } cell_word_type;

   localparam rgb_type PALETTE [TABLE_ENTRIES] = '{
      '{8'd0,   8'd0,   8'd0  }, '{8'd255, 8'd255, 8'd255}, '{8'd170, 8'd170, 8'd170},
      '{8'd85,  8'd85,  8'd85 }, '{8'd254, 8'd211, 8'd199}, '{8'd255, 8'd196, 8'd206},
      '{8'd250, 8'd172, 8'd142}, '{8'd255, 8'd139, 8'd131}, '{8'd244, 8'd67,  8'd54 },
      '{8'd233, 8'd30,  8'd99 }, '{8'd226, 8'd102, 8'd158}, '{8'd156, 8'd39,  8'd176},
      '{8'd103, 8'd58,  8'd183}, '{8'd63,  8'd81,  8'd181}, '{8'd0,   8'd70,  8'd112},
      '{8'd5,   8'd113, 8'd151}, '{8'd33,  8'd150, 8'd243}, '{8'd0,   8'd188, 8'd212},
      '{8'd59,  8'd229, 8'd219}, '{8'd151, 8'd253, 8'd220}, '{8'd22,  8'd115, 8'd0  },
      '{8'd55,  8'd169, 8'd60 }, '{8'd137, 8'd230, 8'd66 }, '{8'd215, 8'd255, 8'd7  },
      '{8'd255, 8'd246, 8'd209}, '{8'd248, 8'd203, 8'd140}, '{8'd255, 8'd235, 8'd59 },
      '{8'd255, 8'd193, 8'd7  }, '{8'd255, 8'd152, 8'd0  }, '{8'd255, 8'd87,  8'd34 },
      '{8'd184, 8'd63,  8'd39 }, '{8'd121, 8'd85,  8'd72 }
   };

   // Base-32 digit of an index: 0-9 then a-v.
   function automatic logic [CHAR_W-1:0] digit_of(input logic [IDX_W-1:0] idx);
      if (idx < DEC_DIGITS) begin
         return CHAR_ZERO + CHAR_W'(idx);
      end else begin
         return CHAR_ALPHA_BASE + CHAR_W'(idx);
      end
   endfunction

endpackage

// File: rtl/npcm_cell.sv
// One cell of the matcher chain: scores the passing pixel against one
// palette entry and keeps the closer of that entry and the best so far.
// Depends on npcm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module npcm_cell
   import npcm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  rgb_type              entry_i,
   input  logic [IDX_W-1:0]     entry_idx_i,
   input  cell_word_type        word_i,
   output cell_word_type        word_o
);

   logic [CHAN_W-1:0] diff_r, diff_g, diff_b;
   logic [SQ_W-1:0]   sq_r, sq_g, sq_b;
   logic [DIST_W-1:0] dist_sum;
   cell_word_type     word_in, word_ff;

   // Absolute channel differences against this cell's palette entry.
   always_comb begin
      diff_r = (word_i.pixel.red >= entry_i.red) ? word_i.pixel.red - entry_i.red
                                                 : entry_i.red - word_i.pixel.red;
      diff_g = (word_i.pixel.green >= entry_i.green) ? word_i.pixel.green - entry_i.green
                                                     : entry_i.green - word_i.pixel.green;
      diff_b = (word_i.pixel.blue >= entry_i.blue) ? word_i.pixel.blue - entry_i.blue
                                                   : entry_i.blue - word_i.pixel.blue;
   end

   // Squared Euclidean distance; it never exceeds 3 * 255 * 255.
   always_comb begin
      sq_r = SQ_W'(diff_r) * SQ_W'(diff_r);
      sq_g = SQ_W'(diff_g) * SQ_W'(diff_g);
      sq_b = SQ_W'(diff_b) * SQ_W'(diff_b);
      dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
   end

   // Only a strictly smaller distance takes over, so the lower index wins ties.
   always_comb begin
      word_in = word_i;
      if (dist_sum < word_i.best_dist) begin
         word_in.best_idx  = entry_idx_i;
         word_in.best_dist = dist_sum;
      end
   end

   // Hand the word to the next cell; only the valid bit needs reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff.valid <= word_in.valid;
      end
      word_ff.pixel     <= word_in.pixel;
      word_ff.row_end   <= word_in.row_end;
      word_ff.best_idx  <= word_in.best_idx;
      word_ff.best_dist <= word_in.best_dist;
   end

   assign word_o = word_ff;

   `NPCM_ASSERT_IMPL(a_dist_never_grows, word_ff.valid, word_ff.best_dist <= $past(word_i.best_dist), "Cell raised the best distance.")
   `NPCM_ASSERT_IMPL(a_idx_not_ahead, word_ff.valid, word_ff.best_idx <= $past(entry_idx_i), "Best index lies beyond this cell.")

endmodule

// File: rtl/nearest_palette_color_match.sv
// Top level of the nearest palette color matcher: the cell chain and the
// result register. Depends on npcm_pkg, npcm_cell and assert_macros.svh.
//
// The block takes one pixel word per clock whenever busy is low and returns,
// for each, the index of the nearest palette entry (smallest squared RGB
// distance, lowest index on ties), its ASCII base-32 digit and a copy of the
// row-end flag. Each palette entry has its own cell in a chain, so a word
// passes one register per entry plus the result register, and the result
// strobe rsp_valid rises as the result register takes the word's result. Results
// leave in order at one per clock. The receiver cannot stall; every result is
// on the rsp_ ports for exactly one cycle. Busy is high during reset and in
// the first cycle after it, and low from then on.
`include "assert_macros.svh"

module nearest_palette_color_match
   import npcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   input  logic              req_row_end,
   output logic              rsp_valid,
   output logic [IDX_W-1:0]  rsp_palette_index,
   output logic [CHAR_W-1:0] rsp_digit_char,
   output logic              rsp_row_last
);

   logic              busy_ff;
   logic              accept;
   cell_word_type     chain [PALETTE_SIZE+1];
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_last_ff;

   // Busy holds off the first cycle after reset only.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // A new word enters with a best distance above any real one.
   always_comb begin
      chain[0].valid       = accept;
      chain[0].pixel.red   = req_red;
      chain[0].pixel.green = req_green;
      chain[0].pixel.blue  = req_blue;
      chain[0].row_end     = req_row_end;
      chain[0].best_idx    = '0;
      chain[0].best_dist   = '1;
   end

   // One cell per palette entry searched.
   for (genvar k = 0; k < PALETTE_SIZE; k++) begin : g_cell
      npcm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .entry_i     (PALETTE[k]),
         .entry_idx_i (IDX_W'(k)),
         .word_i      (chain[k]),
         .word_o      (chain[k+1])
      );
   end

   // Result register with the digit encoding.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain[PALETTE_SIZE].valid;
      end
      rsp_index_ff <= chain[PALETTE_SIZE].best_idx;
      rsp_char_ff  <= digit_of(chain[PALETTE_SIZE].best_idx);
      rsp_last_ff  <= chain[PALETTE_SIZE].row_end;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = rsp_index_ff;
   assign rsp_digit_char    = rsp_char_ff;
   assign rsp_row_last      = rsp_last_ff;

   `NPCM_ASSERT(a_fixed_latency, accept |-> ##(LATENCY) rsp_valid, "Result strobe missing after an accepted word.")
   `NPCM_ASSERT(a_row_end_kept, accept |-> ##(LATENCY) (rsp_row_last == $past(req_row_end, LATENCY)), "Row-end flag changed in the chain.")

endmodule

// File: sim/nearest_palette_color_match_tb.sv
// Self-checking testbench for nearest_palette_color_match: predicts the nearest
// palette entry for each pixel word and checks every result strobe in order.
// Depends on npcm_pkg and the nearest_palette_color_match RTL.
`timescale 1ns / 100ps

module nearest_palette_color_match_tb;
   import npcm_pkg::*;

   localparam int SWATCH_COUNT = 32;
   localparam logic [CHAR_W-1:0] ASCII_DIGIT_ZERO = 7'd48;
   localparam logic [CHAR_W-1:0] ASCII_LETTER_A   = 7'd97;
   localparam int DECIMAL_DIGITS = 10;
   localparam int NEAR_SPREAD    = 6;

   // The palette, as red, green, blue per entry.
   localparam logic [7:0] SWATCH [SWATCH_COUNT][3] = '{
      '{  0,   0,   0}, '{255, 255, 255}, '{170, 170, 170}, '{ 85,  85,  85},
      '{254, 211, 199}, '{255, 196, 206}, '{250, 172, 142}, '{255, 139, 131},
      '{244,  67,  54}, '{233,  30,  99}, '{226, 102, 158}, '{156,  39, 176},
      '{103,  58, 183}, '{ 63,  81, 181}, '{  0,  70, 112}, '{  5, 113, 151},
      '{ 33, 150, 243}, '{  0, 188, 212}, '{ 59, 229, 219}, '{151, 253, 220},
      '{ 22, 115,   0}, '{ 55, 169,  60}, '{137, 230,  66}, '{215, 255,   7},
      '{255, 246, 209}, '{248, 203, 140}, '{255, 235,  59}, '{255, 193,   7},
      '{255, 152,   0}, '{255,  87,  34}, '{184,  63,  39}, '{121,  85,  72}
   };

   typedef struct {
      logic [IDX_W-1:0]  index;
      logic [CHAR_W-1:0] digit;
      logic              row_last;
   } match_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [CHAN_W-1:0] req_red = '0;
   logic [CHAN_W-1:0] req_green = '0;
   logic [CHAN_W-1:0] req_blue = '0;
   logic              req_row_end = 1'b0;
   logic              rsp_valid;
   logic [IDX_W-1:0]  rsp_palette_index;
   logic [CHAR_W-1:0] rsp_digit_char;
   logic              rsp_row_last;

   match_type match_q [$];
   int        error_count = 0;

   nearest_palette_color_match dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_row_end       (req_row_end),
      .rsp_valid         (rsp_valid),
      .rsp_palette_index (rsp_palette_index),
      .rsp_digit_char    (rsp_digit_char),
      .rsp_row_last      (rsp_row_last)
   );

   always #10 clock = ~clock;

   // Nearest entry by squared distance; only a strictly smaller distance
   // replaces the best so far, so the lowest index wins a tie.
   function automatic match_type nearest_match(input logic [CHAN_W-1:0] red,
                                               input logic [CHAN_W-1:0] green,
                                               input logic [CHAN_W-1:0] blue,
                                               input logic row_end);
      match_type result;
      int limit;
      int best;
      int best_dist;
      int cand_dist;
      limit = (PALETTE_SIZE > SWATCH_COUNT) ? SWATCH_COUNT :
              ((PALETTE_SIZE < 1) ? 1 : PALETTE_SIZE);
      best = 0;
      best_dist = 32'h7fffffff;
      for (int k = 0; k < limit; k++) begin
         cand_dist = (int'(red) - int'(SWATCH[k][0])) ** 2 +
                     (int'(green) - int'(SWATCH[k][1])) ** 2 +
                     (int'(blue) - int'(SWATCH[k][2])) ** 2;
         if (cand_dist < best_dist) begin
            best_dist = cand_dist;
            best = k;
         end
      end
      result.index = IDX_W'(best);
      if (best < DECIMAL_DIGITS) begin
         result.digit = ASCII_DIGIT_ZERO + CHAR_W'(best);
      end else begin
         result.digit = ASCII_LETTER_A + CHAR_W'(best - DECIMAL_DIGITS);
      end
      result.row_last = row_end;
      return result;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Result checking and prediction of each accepted word.
   always @(posedge clock) begin : scoreboard
      match_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (match_q.size() == 0) begin
               report_mismatch("unexpected result index", rsp_palette_index, -1);
            end else begin
               want = match_q.pop_front();
               if (rsp_palette_index !== want.index)
                  report_mismatch("palette_index", rsp_palette_index, want.index);
               if (rsp_digit_char !== want.digit)
                  report_mismatch("digit_char", rsp_digit_char, want.digit);
               if (rsp_row_last !== want.row_last)
                  report_mismatch("row_last", rsp_row_last, want.row_last);
            end
         end
         if (start && !busy) begin
            match_q.push_back(nearest_match(req_red, req_green, req_blue, req_row_end));
         end
      end
   end

   // Offers one pixel word and waits until the block takes it.
   task automatic send_pixel(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                             input logic [CHAN_W-1:0] blue, input logic row_end);
      @(negedge clock);
      start       <= 1'b1;
      req_red     <= red;
      req_green   <= green;
      req_blue    <= blue;
      req_row_end <= row_end;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Holds off new words until every expected result has come back.
   task automatic wait_drained();
      idle_sender(1);
      wait (match_q.size() == 0);
   endtask

   function automatic logic [CHAN_W-1:0] near_channel(input logic [7:0] center);
      int value;
      value = int'(center) + $urandom_range(0, 2 * NEAR_SPREAD) - NEAR_SPREAD;
      if (value < 0) value = 0;
      if (value > 255) value = 255;
      return CHAN_W'(value);
   endfunction

   // Corners of the color cube, mid gray, bit patterns, two exact palette entries
   // and an exact tie between entries 27 and 28 that the lower index must win.
   task automatic test_directed();
      send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
      send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
      send_pixel(8'd0,   8'd0,   8'd255, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
      send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0,   8'd255, 1'b1);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
      send_pixel(8'haa,  8'h55,  8'haa,  1'b0);
      send_pixel(8'h55,  8'haa,  8'h55,  1'b1);
      send_pixel(8'd255, 8'd169, 8'd24,  1'b0);
      send_pixel(8'd85,  8'd85,  8'd85,  1'b1);
      send_pixel(8'd121, 8'd85,  8'd72,  1'b1);
      wait_drained();
   endtask

   // Random pixels in rows: many close to a palette entry so every index and
   // near ties come up, the rest uniform or on the channel extremes.
   task automatic test_stream(input int count, input int idle_pct);
      int pick;
      int entry;
      logic [CHAN_W-1:0] red, green, blue;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(1, 100);
         if (pick <= 45) begin
            entry = $urandom_range(0, SWATCH_COUNT - 1);
            red   = near_channel(SWATCH[entry][0]);
            green = near_channel(SWATCH[entry][1]);
            blue  = near_channel(SWATCH[entry][2]);
         end else if (pick <= 90) begin
            red   = CHAN_W'($urandom);
            green = CHAN_W'($urandom);
            blue  = CHAN_W'($urandom);
         end else begin
            red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         end
         if ($urandom_range(1, 100) <= idle_pct) idle_sender($urandom_range(1, 3));
         send_pixel(red, green, blue, $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_stream(400, 0);
      test_stream(400, 53);
      wait_drained();
      test_stream(350, 12);
      test_stream(400, 0);
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/npcm_pkg.sv
rtl/npcm_cell.sv
rtl/nearest_palette_color_match.sv
sim/nearest_palette_color_match_tb.sv
